// ===== design/dtt_pkg.sv =====
package dtt_pkg;

    // Operation codes of an input word
    localparam logic OP_MARK  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // Configuration register indexes
    localparam logic CFG_SCREEN_WIDTH  = 1'b0;
    localparam logic CFG_SCREEN_HEIGHT = 1'b1;

    // Configuration reset values
    localparam logic [9:0] SCREEN_WIDTH_RESET  = 10'd640;
    localparam logic [9:0] SCREEN_HEIGHT_RESET = 10'd480;

    typedef struct packed {
        logic               operation;
        logic signed [11:0] pixel_x;
        logic signed [11:0] pixel_y;
        logic        [5:0]  tile_row;
    } item_t;

    typedef struct packed {
        logic [9:0] rect_x;
        logic [9:0] rect_y;
        logic [9:0] rect_width;
        logic [4:0] rect_height;
        logic       last_rect;
    } result_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_item;
        logic issue_read;
        logic write_mark;
        logic load_scan;
        logic scan_step;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_mark;
        logic mark_ok;
        logic row_ok;
        logic top_ok;
        logic scan_done;
    } status_t;

endpackage

// ===== design/dtt_ram.sv =====
module dtt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one word, read one word registered
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/dtt_datapath.sv =====
module dtt_datapath import dtt_pkg::*; #(
    parameter int TILE_LOG2        = 4,
    parameter int MAX_TILE_COLUMNS = 64,
    parameter int MAX_TILE_ROWS    = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  item_t      item,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [9:0] cfg_data,
    input  cmd_t       cmd,
    output status_t    status,
    output logic       result_valid,
    output result_t    result
);

    localparam int RW   = $clog2(MAX_TILE_ROWS);
    localparam int CIW  = $clog2(MAX_TILE_COLUMNS);
    localparam int CNTW = $clog2(MAX_TILE_COLUMNS + 1);
    localparam int TSZ  = 1 << TILE_LOG2;
    localparam int PW   = (7 + TILE_LOG2 > 11) ? 7 + TILE_LOG2 : 11;
    localparam int TW   = (6 + TILE_LOG2 > 11) ? 6 + TILE_LOG2 : 11;

    item_t                       item_reg;
    logic [9:0]                  sw_reg;
    logic [9:0]                  sh_reg;
    logic                        row_valid_reg [MAX_TILE_ROWS];
    logic                        rd_valid_reg;
    logic [MAX_TILE_COLUMNS-1:0] scan_reg;
    logic [CNTW-1:0]             col_reg;
    logic                        in_run_reg;
    logic [CNTW-1:0]             run_start_reg;
    logic [4:0]                  height_reg;
    logic                        result_valid_reg;
    result_t                     result_reg;

    logic [10:0]                 cols_sum;
    logic [CNTW-1:0]             cols;
    logic [MAX_TILE_COLUMNS-1:0] col_mask;
    logic [10:0]                 mark_c;
    logic [10:0]                 mark_r;
    logic [10:0]                 flush_r;
    logic [RW-1:0]               row_addr;
    logic [MAX_TILE_COLUMNS-1:0] rd_word;
    logic [MAX_TILE_COLUMNS-1:0] ram_rdata;
    logic [MAX_TILE_COLUMNS-1:0] mark_word;
    logic [TW-1:0]               top_full;
    logic [TW-1:0]               height_diff;
    logic [TW-1:0]               height_full;
    logic [PW-1:0]               left;
    logic [PW-1:0]               right_raw;
    logic [PW-1:0]               right;
    logic [PW-1:0]               width;
    logic                        run_end;

    // Tile columns in use, and the mask of those columns
    assign cols_sum = 11'(sw_reg >> TILE_LOG2) + 11'd1;
    assign cols = (cols_sum > 11'(MAX_TILE_COLUMNS)) ? CNTW'(MAX_TILE_COLUMNS)
                                                     : cols_sum[CNTW-1:0];

    always_comb
    begin
        for (int i = 0; i < MAX_TILE_COLUMNS; i++)
        begin
            col_mask[i] = (CNTW'(i) < cols);
        end
    end

    // Tile of a marked pixel, and the row to access
    assign mark_c  = item_reg.pixel_x[10:0] >> TILE_LOG2;
    assign mark_r  = item_reg.pixel_y[10:0] >> TILE_LOG2;
    assign flush_r = 11'(item_reg.tile_row);
    assign row_addr = (item_reg.operation == OP_MARK) ? mark_r[RW-1:0] : flush_r[RW-1:0];

    // Top edge and clipped height of the flushed row
    assign top_full    = TW'(item_reg.tile_row) << TILE_LOG2;
    assign height_diff = TW'(sh_reg) - top_full;
    assign height_full = (height_diff < TW'(TSZ)) ? height_diff : TW'(TSZ);

    assign status.is_mark = (item_reg.operation == OP_MARK);
    assign status.mark_ok = !item_reg.pixel_x[11] && !item_reg.pixel_y[11]
                         && (item_reg.pixel_x[10:0] < {1'b0, sw_reg})
                         && (item_reg.pixel_y[10:0] < {1'b0, sh_reg})
                         && (mark_c < 11'(cols))
                         && (mark_r < 11'(MAX_TILE_ROWS));
    assign status.row_ok    = (flush_r < 11'(MAX_TILE_ROWS));
    assign status.top_ok    = (top_full < TW'(sh_reg));
    assign status.scan_done = (scan_reg == '0) && !in_run_reg;

    // Row store; a row never written since its last clear reads as empty
    dtt_ram #(
        .WIDTH (MAX_TILE_COLUMNS),
        .DEPTH (MAX_TILE_ROWS)
    ) u_rows (
        .clk   (clk),
        .we    (cmd.write_mark),
        .waddr (row_addr),
        .wdata (mark_word),
        .re    (cmd.issue_read),
        .raddr (row_addr),
        .rdata (ram_rdata)
    );

    assign rd_word   = rd_valid_reg ? ram_rdata : '0;
    assign mark_word = rd_word | (MAX_TILE_COLUMNS'(1) << mark_c[CIW-1:0]);

    // Rectangle of the run that ends at the current column
    assign left      = PW'(run_start_reg) << TILE_LOG2;
    assign right_raw = PW'(col_reg) << TILE_LOG2;
    assign right     = (right_raw > PW'(sw_reg)) ? PW'(sw_reg) : right_raw;
    assign width     = (right > left) ? right - left : '0;
    assign run_end   = cmd.scan_step && in_run_reg && !scan_reg[0];

    // Configuration registers and row valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_reg <= SCREEN_WIDTH_RESET;
            sh_reg <= SCREEN_HEIGHT_RESET;
            for (int i = 0; i < MAX_TILE_ROWS; i++)
            begin
                row_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_SCREEN_WIDTH)
                begin
                    sw_reg <= cfg_data;
                end
                else
                begin
                    sh_reg <= cfg_data;
                end
            end
            if (cmd.write_mark)
            begin
                row_valid_reg[row_addr] <= 1'b1;
            end
            else if (cmd.load_scan)
            begin
                row_valid_reg[row_addr] <= 1'b0;
            end
        end
    end

    // Scan control state and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_run_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= run_end;
            if (cmd.load_scan)
            begin
                in_run_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                in_run_reg <= scan_reg[0];
            end
        end
    end

    // Hold the item, latch the row valid bit, load and step the scan, capture each rectangle
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= item;
        end
        if (cmd.issue_read)
        begin
            rd_valid_reg <= row_valid_reg[row_addr];
        end
        if (cmd.load_scan)
        begin
            scan_reg   <= rd_word & col_mask;
            col_reg    <= '0;
            height_reg <= height_full[4:0];
        end
        else if (cmd.scan_step)
        begin
            scan_reg <= scan_reg >> 1;
            col_reg  <= col_reg + CNTW'(1);
            if (scan_reg[0] && !in_run_reg)
            begin
                run_start_reg <= col_reg;
            end
        end
        if (run_end)
        begin
            result_reg.rect_x      <= left[9:0];
            result_reg.rect_y      <= top_full[9:0];
            result_reg.rect_width  <= width[9:0];
            result_reg.rect_height <= height_reg;
            result_reg.last_rect   <= (scan_reg == '0);
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== design/dtt_ctrl.sv =====
module dtt_ctrl import dtt_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  status_t status,
    output logic    busy,
    output cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_ISSUE  = 5'b00010,
        ST_MODIFY = 5'b00100,
        ST_LOAD   = 5'b01000,
        ST_SCAN   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Sequence one word: read the row, then update it or scan it
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                cmd.issue_read = 1'b1;
                if (status.is_mark)
                begin
                    state_next = status.mark_ok ? ST_MODIFY : ST_IDLE;
                end
                else
                begin
                    state_next = status.row_ok ? ST_LOAD : ST_IDLE;
                end
            end
            ST_MODIFY:
            begin
                cmd.write_mark = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_LOAD:
            begin
                cmd.load_scan = 1'b1;
                state_next    = status.top_ok ? ST_SCAN : ST_IDLE;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ===== design/dirty_tile_tracker_core.sv =====
// Dirty tile tracker: keeps one dirty bit per screen tile and turns a tile
// row into redraw rectangles.
// Input channel: drive item and raise start; the word is taken at a clock
// edge where start is high and busy is low. A mark word sets the bit of the
// tile holding an on-screen pixel; a flush word names a tile row.
// Result channel: result_valid is high for one cycle with each rectangle;
// last_rect marks the final one of a flush. Results cannot be held off.
// Configuration: cfg_we with cfg_index (0 width, 1 height) and cfg_data, to be
// written by the user only while busy is low; the block does not enforce it.
// Sequence: a mark reads its row, then writes it back through the row
// memory's write port. A flush reads and loads the row, then scans the tile
// columns in turn up to the last dirty column, closes the final run and
// finishes. A rectangle's run end is found at the scan step past its last
// column, and the rectangle is then registered onto result; the bit-serial
// column scan sets the flush rate.
// Reset clears all dirty bits at once through per-row valid flags and sets
// the screen to 640 by 480; the block is ready in the first cycle after.
module dirty_tile_tracker_core import dtt_pkg::*; #(
    parameter int TILE_LOG2        = 4,
    parameter int MAX_TILE_COLUMNS = 64,
    parameter int MAX_TILE_ROWS    = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  item_t      item,
    output logic       result_valid,
    output result_t    result,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [9:0] cfg_data
);

    cmd_t    cmd;
    status_t status;

    // Sequence each word
    dtt_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    // Hold the tile store, the configuration and the scan
    dtt_datapath #(
        .TILE_LOG2        (TILE_LOG2),
        .MAX_TILE_COLUMNS (MAX_TILE_COLUMNS),
        .MAX_TILE_ROWS    (MAX_TILE_ROWS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

// ===== tb/dirty_tile_tracker_core_test.sv =====
module dirty_tile_tracker_core_test;
    import dtt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TILE_LOG2   = 4;
    localparam int TILE_SIZE   = 1 << TILE_LOG2;
    localparam int MAX_COLUMNS = 64;
    localparam int MAX_ROWS    = 64;
    // Time for the longest flush to finish, with a margin
    localparam int DRAIN_CYCLES = MAX_COLUMNS + 8;
    localparam int STALL_LIMIT  = 3000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    item_t      item = '0;
    logic       result_valid;
    result_t    result;
    logic       cfg_we = 1'b0;
    logic       cfg_index = CFG_SCREEN_WIDTH;
    logic [9:0] cfg_data = '0;

    // Shadow of the tile bitmap and the screen registers
    logic [63:0] dirty_map [MAX_ROWS];
    logic [9:0]  screen_w = SCREEN_WIDTH_RESET;
    logic [9:0]  screen_h = SCREEN_HEIGHT_RESET;

    result_t rect_queue [$];
    int      fail_count = 0;
    int      burst_left = 0;
    int      idle_cycles = 0;

    dirty_tile_tracker_core #(
        .TILE_LOG2       (TILE_LOG2),
        .MAX_TILE_COLUMNS(MAX_COLUMNS),
        .MAX_TILE_ROWS   (MAX_ROWS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .item        (item),
        .result_valid(result_valid),
        .result      (result),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        foreach (dirty_map[i])
            dirty_map[i] = '0;
    end

    function automatic int unsigned column_count();
        int unsigned n;
        n = (int'(screen_w) >> TILE_LOG2) + 1;
        if (n > MAX_COLUMNS)
            n = MAX_COLUMNS;
        return n;
    endfunction

    function automatic int unsigned row_count();
        int unsigned n;
        n = (int'(screen_h) >> TILE_LOG2) + 1;
        if (n > MAX_ROWS)
            n = MAX_ROWS;
        return n;
    endfunction

    // Apply one accepted word to the shadow bitmap and queue its rectangles
    task automatic predict_rects(input item_t w);
        int          x;
        int          y;
        int unsigned r;
        int unsigned c;
        int unsigned n;
        int unsigned cols;
        int unsigned top;
        int unsigned tall;
        int unsigned left;
        int unsigned right;
        int          added;
        logic [63:0] bits;
        result_t     rect;
        added = 0;
        if (w.operation == OP_MARK)
        begin
            x = int'($signed(w.pixel_x));
            y = int'($signed(w.pixel_y));
            if (x >= 0 && y >= 0 && x < int'(screen_w) && y < int'(screen_h))
            begin
                c = x >> TILE_LOG2;
                r = y >> TILE_LOG2;
                if (c < column_count() && r < row_count())
                    dirty_map[r][c] = 1'b1;
            end
            return;
        end
        r = w.tile_row;
        if (r >= MAX_ROWS)
            return;
        // Clear the row even when it lies below the screen
        bits = dirty_map[r];
        dirty_map[r] = '0;
        top = r << TILE_LOG2;
        if (top >= screen_h)
            return;
        tall = screen_h - top;
        if (tall > TILE_SIZE)
            tall = TILE_SIZE;
        cols = column_count();
        c = 0;
        while (c < cols)
        begin
            if (bits[c])
            begin
                n = 1;
                while (c + n < cols && bits[c + n])
                    n++;
                left  = c << TILE_LOG2;
                right = left + (n << TILE_LOG2);
                if (right > screen_w)
                    right = screen_w;
                rect.rect_x      = 10'(left);
                rect.rect_y      = 10'(top);
                rect.rect_width  = (right > left) ? 10'(right - left) : 10'd0;
                rect.rect_height = 5'(tall);
                rect.last_rect   = 1'b0;
                rect_queue.push_back(rect);
                added++;
                c += n;
            end
            else
                c++;
        end
        if (added > 0)
            rect_queue[$].last_rect = 1'b1;
    endtask

    task automatic report_mismatch(input string what, input int got, input int wanted);
        $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, wanted);
        fail_count++;
    endtask

    // Mostly short gaps, a few long ones, and bursts with none
    function automatic int next_gap();
        int pick;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            burst_left = $urandom_range(5, 20);
            return 0;
        end
        if (pick < 60)
            return $urandom_range(0, 2);
        if (pick < 92)
            return $urandom_range(3, 8);
        return $urandom_range(20, 40);
    endfunction

    // Offer one word and hold it until the block takes it
    task automatic send_word(input item_t w);
        int gap;
        gap = next_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            item  <= item_t'($urandom);
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item  <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_rects(w);
    endtask

    function automatic item_t mark_word(input int x, input int y);
        item_t w;
        w = item_t'($urandom);
        w.operation = OP_MARK;
        w.pixel_x   = 12'(x);
        w.pixel_y   = 12'(y);
        return w;
    endfunction

    function automatic item_t flush_word(input int unsigned row);
        item_t w;
        w = item_t'($urandom);
        w.operation = OP_FLUSH;
        w.tile_row  = 6'(row);
        return w;
    endfunction

    // Drop start, drain every rectangle, then let a silent flush finish
    task automatic settle();
        start <= 1'b0;
        while (rect_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic idx, input logic [9:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        if (idx == CFG_SCREEN_WIDTH)
            screen_w = value;
        else
            screen_h = value;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Reset screen of 640 by 480: on-screen corners, off-screen marks, rows past the bottom
    task automatic test_default_screen();
        send_word(mark_word(0, 0));
        send_word(mark_word(639, 479));
        send_word(mark_word(640, 0));
        send_word(mark_word(-1, 0));
        send_word(mark_word(0, -2048));
        send_word(mark_word(2047, 2047));
        send_word(mark_word(16, 0));
        send_word(mark_word(100, 480));
        send_word(flush_word(0));
        send_word(flush_word(29));
        send_word(flush_word(30));
        send_word(flush_word(63));
        send_word(flush_word(0));
    endtask

    // Full-size screen, then shrink the width under marked tiles
    task automatic test_edge_clipping();
        settle();
        write_register(CFG_SCREEN_WIDTH, 10'd1023);
        write_register(CFG_SCREEN_HEIGHT, 10'd1023);
        send_word(mark_word(1022, 1022));
        send_word(mark_word(640, 16));
        send_word(mark_word(1000, 32));
        send_word(mark_word(48, 32));
        send_word(flush_word(63));
        settle();
        write_register(CFG_SCREEN_WIDTH, 10'd640);
        // run at the right edge gives zero width; column past the edge is dropped
        send_word(flush_word(1));
        send_word(flush_word(2));
        settle();
        write_register(CFG_SCREEN_WIDTH, 10'd1023);
        send_word(flush_word(2));
    endtask

    // One-pixel screen
    task automatic test_tiny_screen();
        settle();
        write_register(CFG_SCREEN_WIDTH, 10'd1);
        write_register(CFG_SCREEN_HEIGHT, 10'd1);
        send_word(mark_word(0, 0));
        send_word(mark_word(1, 0));
        send_word(flush_word(0));
        send_word(flush_word(1));
    endtask

    // Marks clustered on a few rows, flushes of those rows, and random noise
    task automatic test_random_traffic();
        int unsigned widths [5];
        int unsigned heights [5];
        int unsigned hot [3];
        int unsigned max_row;
        int unsigned pick;
        item_t       w;
        widths  = '{1023, 48, 0, 640, 1023};
        heights = '{1023, 1023, 0, 17, 5};
        for (int p = 0; p < 5; p++)
        begin
            settle();
            write_register(CFG_SCREEN_WIDTH,
                           widths[p] != 0 ? 10'(widths[p]) : 10'($urandom_range(1, 1023)));
            write_register(CFG_SCREEN_HEIGHT,
                           heights[p] != 0 ? 10'(heights[p]) : 10'($urandom_range(1, 1023)));
            max_row = (int'(screen_h) - 1) >> TILE_LOG2;
            foreach (hot[i])
                hot[i] = $urandom_range(0, max_row);
            for (int n = 0; n < 17; n++)
            begin
                w    = item_t'($urandom);
                pick = $urandom_range(0, 99);
                if (pick >= 12 && pick < 72)
                begin
                    w.operation = OP_MARK;
                    w.pixel_x   = 12'($urandom_range(0, int'(screen_w) - 1));
                    w.pixel_y   = 12'((hot[$urandom_range(0, 2)] << TILE_LOG2)
                                      + $urandom_range(0, TILE_SIZE - 1));
                end
                else if (pick >= 72)
                begin
                    w.operation = OP_FLUSH;
                    w.tile_row  = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                              : 6'(hot[$urandom_range(0, 2)]);
                end
                send_word(w);
            end
        end
    endtask

    // Compare each rectangle with the oldest one predicted
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid)
        begin
            if (rect_queue.size() == 0)
                report_mismatch("rectangle with none pending, rect_x", result.rect_x, -1);
            else
            begin
                want = rect_queue.pop_front();
                if (result.rect_x !== want.rect_x)
                    report_mismatch("rect_x", result.rect_x, want.rect_x);
                if (result.rect_y !== want.rect_y)
                    report_mismatch("rect_y", result.rect_y, want.rect_y);
                if (result.rect_width !== want.rect_width)
                    report_mismatch("rect_width", result.rect_width, want.rect_width);
                if (result.rect_height !== want.rect_height)
                    report_mismatch("rect_height", result.rect_height, want.rect_height);
                if (result.last_rect !== want.last_rect)
                    report_mismatch("last_rect", result.last_rect, want.last_rect);
            end
        end
    end

    // Abort when neither a word nor a rectangle moves for too long
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_default_screen();
        test_edge_clipping();
        test_tiny_screen();
        test_random_traffic();
        settle();
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
